@@ rtl/bounded_number_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Bounded number parser: assertion macros
// Shared property forms for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_NUMBER_PARSER_UNIT_ASSERT_SVH
`define BOUNDED_NUMBER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BNP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bounded number parser: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bounded number parser: next-cycle check failed");

`endif

@@ rtl/bnp_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded number parser package
// Types, codes and character constants shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bnp_pkg;

  localparam int unsigned ValW  = 64;
  localparam int unsigned ChW   = 8;
  localparam int unsigned BaseW = 6;
  localparam int unsigned StatW = 2;
  localparam int unsigned IdxW  = 2;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_MIN   = 2'd0;
  localparam logic [IdxW-1:0] REG_MAX   = 2'd1;
  localparam logic [IdxW-1:0] REG_RADIX = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_BAD   = 2'd1;
  localparam logic [StatW-1:0] ST_BIG   = 2'd2;
  localparam logic [StatW-1:0] ST_SMALL = 2'd3;

  // Characters
  localparam logic [ChW-1:0] CH_NUL   = 8'h00;
  localparam logic [ChW-1:0] CH_SPACE = 8'h20;
  localparam logic [ChW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [ChW-1:0] CH_MINUS = 8'h2D;
  localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ChW-1:0] CH_NINE  = 8'h39;
  localparam logic [ChW-1:0] CH_UP_A  = 8'h41;
  localparam logic [ChW-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [ChW-1:0] CH_LO_A  = 8'h61;
  localparam logic [ChW-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [ChW-1:0] CH_LO_X  = 8'h78;
  localparam logic [ChW-1:0] CH_TAB   = 8'h09;
  localparam logic [ChW-1:0] CH_CR    = 8'h0D;
  localparam logic [ChW-1:0] CASE_OFS = 8'd32;

  // Bases and digit codes
  localparam logic [BaseW-1:0] RADIX_AUTO = 6'd0;
  localparam logic [BaseW-1:0] RADIX_ONE  = 6'd1;
  localparam logic [BaseW-1:0] BASE_OCT   = 6'd8;
  localparam logic [BaseW-1:0] BASE_DEC   = 6'd10;
  localparam logic [BaseW-1:0] BASE_HEX   = 6'd16;
  localparam logic [BaseW-1:0] BASE_TOP   = 6'd36;
  localparam logic [BaseW-1:0] DIG_NONE   = 6'd36;
  localparam logic [BaseW-1:0] DIG_ALPHA  = 6'd10;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_SPACE  = 5'b00001,
    PH_BASE   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  // Controller state, one-hot
  typedef enum logic [1:0] {
    CS_RUN   = 2'b01,
    CS_CHECK = 2'b10
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic step;   // consume one text byte
    logic close;  // consume the terminating byte, latch the raw result
    logic load;   // range-check the raw result into the output register
  } bnp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic nul;    // the offered byte ends the text
  } bnp_sts_t;

endpackage

`default_nettype wire

@@ rtl/bnp_dp.sv @@
// ----------------------------------------------------------------------------
// Bounded number parser datapath
// Configuration registers, parse state, digit multiply-add and range check.
// ----------------------------------------------------------------------------
`default_nettype none

module bnp_dp (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [bnp_pkg::IdxW-1:0]        cfg_idx_i,
  input  wire  [bnp_pkg::ValW-1:0]        cfg_data_i,
  input  wire  [bnp_pkg::ChW-1:0]         ch_i,
  input  wire  bnp_pkg::bnp_cmd_t         cmd_i,
  output bnp_pkg::bnp_sts_t               sts_o,
  output logic [bnp_pkg::ValW-1:0]        value_o,
  output logic [bnp_pkg::StatW-1:0]       status_o
);
  import bnp_pkg::*;

  localparam int unsigned ProdW = ValW + BaseW;

  logic [ValW-1:0]  min_q, max_q;
  logic [BaseW-1:0] radix_q;

  phase_e           phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [ValW-1:0]  acc_q, acc_d;
  logic [BaseW-1:0] base_q, base_d;
  logic             garb_q, garb_d;

  logic [ValW-1:0]  fin_val_q;
  logic             fin_bad_q;
  logic [ValW-1:0]  value_q;
  logic [StatW-1:0] status_q;

  logic [ChW-1:0]   ch_low;
  logic [BaseW-1:0] digit;
  logic             blank;

  assign sts_o.nul = (ch_i == CH_NUL);
  assign blank     = (ch_i == CH_SPACE) || (ch_i inside {[CH_TAB:CH_CR]});

  // Fold case and decode one digit; anything else decodes to a code that no base accepts.
  always_comb begin
    ch_low = ch_i;
    if (ch_i inside {[CH_UP_A:CH_UP_Z]}) begin
      ch_low = ch_i + CASE_OFS;
    end
    digit = DIG_NONE;
    if (ch_low inside {[CH_ZERO:CH_NINE]}) begin
      digit = BaseW'(ch_low - CH_ZERO);
    end else if (ch_low inside {[CH_LO_A:CH_LO_Z]}) begin
      digit = BaseW'(ch_low - CH_LO_A) + DIG_ALPHA;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= '1;
      radix_q <= RADIX_AUTO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN:   min_q   <= cfg_data_i;
        REG_MAX:   max_q   <= cfg_data_i;
        REG_RADIX: radix_q <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  // Parse step
  always_comb begin
    logic             choose;
    logic             run_digit;
    logic [BaseW-1:0] step_base;
    logic [ProdW-1:0] sum;

    phase_d   = phase_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    base_d    = base_q;
    garb_d    = garb_q;
    choose    = 1'b0;
    run_digit = 1'b0;
    step_base = base_q;
    sum       = '0;

    if (cmd_i.close) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      acc_d   = '0;
      base_d  = '0;
      garb_d  = 1'b0;
    end else if (cmd_i.step) begin
      case (phase_q)
        PH_SPACE: begin
          if (!blank) begin
            if ((ch_i == CH_PLUS) || (ch_i == CH_MINUS)) begin
              neg_d   = (ch_i == CH_MINUS);
              phase_d = PH_BASE;
            end else begin
              choose = 1'b1;
            end
          end
        end
        PH_BASE:   choose = 1'b1;
        PH_ZERO: begin
          phase_d = PH_DIGITS;
          if (ch_i == CH_LO_X) begin
            base_d = BASE_HEX;
          end else begin
            run_digit = 1'b1;
          end
        end
        PH_DIGITS: run_digit = 1'b1;
        default: ;
      endcase

      if (choose) begin
        if (((radix_q == RADIX_AUTO) || (radix_q == BASE_HEX)) && (ch_i == CH_ZERO)) begin
          base_d  = (radix_q == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
          phase_d = PH_ZERO;
        end else begin
          step_base = (radix_q == RADIX_AUTO) ? BASE_DEC : radix_q;
          base_d    = step_base;
          phase_d   = PH_DIGITS;
          run_digit = 1'b1;
        end
      end

      if (run_digit) begin
        sum = ({{BaseW{1'b0}}, acc_q} * {{ValW{1'b0}}, step_base})
            + {{ValW{1'b0}}, digit};
        if (digit >= step_base) begin
          garb_d  = 1'b1;
          phase_d = PH_DONE;
        end else if (|sum[ProdW-1:ValW]) begin
          acc_d   = '1;
          garb_d  = 1'b1;
          phase_d = PH_DONE;
        end else begin
          acc_d = sum[ValW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      base_q  <= '0;
      garb_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      garb_q  <= garb_d;
    end
  end

  // Latch the signed-wrapped value and validity at the terminating byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      fin_val_q <= neg_q ? (ValW'(0) - acc_q) : acc_q;
      fin_bad_q <= (radix_q == RADIX_ONE) || (radix_q > BASE_TOP) || garb_q;
    end
  end

  // Range check into the output register: max first, then min
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (fin_bad_q) begin
        value_q  <= '0;
        status_q <= ST_BAD;
      end else begin
        value_q <= fin_val_q;
        if (fin_val_q > max_q) begin
          status_q <= ST_BIG;
        end else if (fin_val_q < min_q) begin
          status_q <= ST_SMALL;
        end else begin
          status_q <= ST_OK;
        end
      end
    end
  end

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

@@ rtl/bnp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded number parser controller
// Input/output handshakes and sequencing of the closing range check.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_number_parser_unit_assert.svh"

module bnp_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  wire bnp_pkg::bnp_sts_t sts_i,
  output bnp_pkg::bnp_cmd_t  cmd_o
);
  import bnp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign in_stall_o = (state_q != CS_RUN);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.step  = accept && !sts_i.nul;
    cmd_o.close = accept && sts_i.nul;
    cmd_o.load  = 1'b0;
    case (state_q)
      CS_RUN: begin
        if (cmd_o.close) begin
          state_d = CS_CHECK;
        end
      end
      CS_CHECK: begin
        // hold until the output register is free or being emptied
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = CS_RUN;
        end
      end
      default: state_d = CS_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BNP_ASSERT_NEXT(a_close_enters_check, cmd_o.close, (state_q == CS_CHECK) && in_stall_o)
  `BNP_ASSERT_NEXT(a_load_shows_word, cmd_o.load, out_valid_q && (state_q == CS_RUN))
  `BNP_ASSERT_NEXT(a_check_waits, (state_q == CS_CHECK) && out_valid_q && out_stall_i, (state_q == CS_CHECK))
  `BNP_ASSERT_NOW(a_no_load_outside_check, cmd_o.load, (state_q == CS_CHECK) && !accept)

endmodule

`default_nettype wire

@@ rtl/bounded_number_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Bounded number parser unit
// Parses a NUL-terminated byte stream into a range-checked 64-bit value.
// ----------------------------------------------------------------------------
// Feed the text one byte per word on the input channel; every byte other than
// NUL is accepted back to back, even while a finished result still waits on
// the output channel. The NUL word closes the text and latches the signed
// value; the unit then moves to the range-check stage (compare against max,
// then min) and stalls input there; the check stage holds further while the
// previous result sits untaken in the output register. Status 0 means the
// value is valid, 1 marks bad text, overflow or a bad radix (value then
// reads 0), 2 too big, 3 too small.
// Write min, max and radix only while no text is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_number_parser_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration write port
  input  wire                            cfg_we_i,
  input  wire  [bnp_pkg::IdxW-1:0]       cfg_idx_i,
  input  wire  [bnp_pkg::ValW-1:0]       cfg_data_i,
  // text bytes in
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [bnp_pkg::ChW-1:0]        ch_i,
  // results out
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [bnp_pkg::ValW-1:0]       value_o,
  output logic [bnp_pkg::StatW-1:0]      status_o
);
  import bnp_pkg::*;

  bnp_cmd_t cmd;
  bnp_sts_t sts;

  // Sequencing and handshakes
  bnp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Parse state, digit multiply-add and range check
  bnp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ch_i       (ch_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .value_o    (value_o),
    .status_o   (status_o)
  );

endmodule

`default_nettype wire
